>>> rtl/vpdds_pkg.sv
// ----------------------------------------------------------------------------
// vpdds_pkg
// Types, constants and register codes for the vapor pressure deficit block.
// ----------------------------------------------------------------------------
package vpdds_pkg;

  // Defaults for the top level parameters.
  localparam int SCALE_FRAC_BITS_DEF   = 12;
  localparam int EXP_TABLE_ENTRIES_DEF = 256;

  // Q30 constants for the exponential.
  localparam logic [63:0] LOG2E_Q30 = 64'd1549082005;
  localparam logic [63:0] LN2_Q30   = 64'd744261118;
  localparam logic [63:0] ONE_Q30   = 64'd1073741824;

  // Field widths.
  localparam int TEMP_W    = 15;
  localparam int HUM_W     = 14;
  localparam int DEFICIT_W = 26;
  localparam int SCALE_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Register reset values.
  localparam logic [CFG_W-1:0] REFERENCE_RST = 16'd1000;
  localparam logic [CFG_W-1:0] FLOOR_RST     = 16'd2048;
  localparam logic [CFG_W-1:0] CEILING_RST   = 16'd8192;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING   = 2'd2;

  // Clamp flag codes.
  localparam logic [1:0] CLAMP_NONE    = 2'd0;
  localparam logic [1:0] CLAMP_FLOOR   = 2'd1;
  localparam logic [1:0] CLAMP_CEILING = 2'd2;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature_centi_c;
    logic [HUM_W-1:0]         humidity_centi_pct;
  } sample_t;

  typedef struct packed {
    logic [DEFICIT_W-1:0] deficit_centi_pa;
    logic [SCALE_W-1:0]   dose_scale;
    logic [1:0]           clamp_flag;
  } result_t;

endpackage

>>> rtl/vpdds_div.sv
// ----------------------------------------------------------------------------
// vpdds_div
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag for quotients that do not fit and a side word that travels along.
// ----------------------------------------------------------------------------
module vpdds_div #(
  parameter int NW = 56,
  parameter int DW = 36,
  parameter int QW = 22,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic          ovf,
  output logic [SW-1:0] side_out
);

  localparam int W = (NW > DW + QW) ? NW : DW + QW;

  logic          vld  [0:QW];
  logic [W-1:0]  rem  [0:QW];
  logic [DW-1:0] dvs  [0:QW];
  logic [QW-1:0] qacc [0:QW];
  logic          ovfs [0:QW];
  logic [SW-1:0] sds  [0:QW];

  // Entry stage: capture operands and check whether the quotient fits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    rem[0]  <= W'(num);
    dvs[0]  <= den;
    qacc[0] <= '0;
    ovfs[0] <= W'(num) >= (W'(den) << QW);
    sds[0]  <= side;
  end

  // Each stage settles one quotient bit, most significant first.
  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [W-1:0] trial;
    logic         ge;

    assign trial = W'(dvs[k-1]) << (QW - k);
    assign ge    = rem[k-1] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
      rem[k]  <= ge ? rem[k-1] - trial : rem[k-1];
      dvs[k]  <= dvs[k-1];
      qacc[k] <= (qacc[k-1] << 1) | QW'(ge);
      ovfs[k] <= ovfs[k-1];
      sds[k]  <= sds[k-1];
    end
  end

  assign out_valid = vld[QW];
  assign quo       = qacc[QW];
  assign ovf       = ovfs[QW];
  assign side_out  = sds[QW];

endmodule

>>> rtl/vapor_pressure_deficit_dose_scale.sv
// ----------------------------------------------------------------------------
// vapor_pressure_deficit_dose_scale
// Tetens saturation pressure, vapor pressure deficit and clamped dose scale.
// ----------------------------------------------------------------------------
// Usage:
// A sample is taken on a rising edge with start high and busy low. busy is
// always low, so a new sample may be issued in every cycle and the block
// sustains one sample per clock.
// The result for a sample appears on result with done high for exactly one
// cycle. The path runs through two pipelined dividers, one quotient bit per
// stage after an entry stage: 23 stages for the exponent and 17 for the dose
// scale, plus ten stages for the multipliers, the table lookup, the reciprocal
// divide by 10000 and the clamp.
// Results come out in sample order; the receiver cannot stall, so no
// backpressure exists and the pipeline never holds.
// Registers are written on the configuration channel (cfg_ready is always
// high); the user must write them only while no sample is in flight; the
// block does not enforce it. Writes to unused indexes are dropped. Reset
// clears pipeline valids, loads reference 1000 Pa, floor 0.5, ceiling 2.0 (Q4.12).
// ----------------------------------------------------------------------------
module vapor_pressure_deficit_dose_scale
  import vpdds_pkg::*;
#(
  parameter int SCALE_FRAC_BITS   = SCALE_FRAC_BITS_DEF,
  parameter int EXP_TABLE_ENTRIES = EXP_TABLE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  sample_t              sample,
  output logic                 done,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int EXP_BITS = $clog2(EXP_TABLE_ENTRIES);
  localparam int QA       = 22;
  localparam int QC       = SCALE_W;
  localparam int NWA      = 56;
  localparam int DWA      = 36;
  localparam int NWB      = 44;
  localparam int NWC      = DEFICIT_W + SCALE_FRAC_BITS + 1;
  localparam int DWC      = 23;
  localparam int LAT      = 10 + QA + QC + 2;

  // Reciprocal of 625 scaled by 2^45, exact for every quotient that fits the field.
  localparam logic [35:0]    RECIP_625 = 36'd56294995343;
  // Smallest t whose deficit no longer fits the field.
  localparam logic [NWB-1:0] T_SAT     = 44'd671088640000;

  // Table of 2^(k/N) in Q30 built from a truncating Taylor series.
  typedef logic [31:0] tab_t [0:EXP_TABLE_ENTRIES];

  function automatic tab_t build_tab();
    tab_t        tab;
    logic [63:0] u;
    logic [63:0] sum;
    logic [63:0] term;
    for (int k = 0; k < EXP_TABLE_ENTRIES; k++) begin
      u    = (64'(k) * LN2_Q30) / EXP_TABLE_ENTRIES;
      sum  = ONE_Q30;
      term = ONE_Q30;
      for (int n = 1; n <= 24; n++) begin
        term = ((term * u) >> 30) / 64'(n);
        sum  = sum + term;
      end
      tab[k] = 32'(sum);
    end
    tab[EXP_TABLE_ENTRIES] = 32'(ONE_Q30 << 1);
    return tab;
  endfunction

  localparam tab_t POW2_TAB = build_tab();

  // Configuration registers.
  logic [CFG_W-1:0] reference_deficit_pa;
  logic [CFG_W-1:0] scale_floor;
  logic [CFG_W-1:0] scale_ceiling;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_deficit_pa <= REFERENCE_RST;
      scale_floor          <= FLOOR_RST;
      scale_ceiling        <= CEILING_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_REFERENCE: reference_deficit_pa <= cfg_data;
        REG_FLOOR:     scale_floor          <= cfg_data;
        REG_CEILING:   scale_ceiling        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Stage 1: magnitude, denominator and humidity saturation.
  logic                     s1_vld;
  logic                     s1_neg;
  logic [24:0]              s1_prod;
  logic [15:0]              s1_den;
  logic [HUM_W-1:0]         s1_h;
  logic signed [TEMP_W-1:0] tc;
  logic [TEMP_W-1:0]        mag;
  logic signed [16:0]       den_s;

  assign tc    = sample.temperature_centi_c;
  assign mag   = tc[TEMP_W-1] ? TEMP_W'(-tc) : TEMP_W'(tc);
  assign den_s = 17'(tc) + 17'sd23730;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start && !busy;
    end
    s1_neg  <= tc[TEMP_W-1];
    s1_prod <= 25'(mag) * 25'd1727;
    s1_den  <= den_s[15:0];
    s1_h    <= (sample.humidity_centi_pct > 14'd10000) ? 14'd10000
                                                       : sample.humidity_centi_pct;
  end

  // Stage 2: exponent numerator with half the divisor added, and the divisor.
  logic             s2_vld;
  logic [NWA-1:0]   s2_num;
  logic [DWA-1:0]   s2_dd;
  logic [HUM_W:0]   s2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_num  <= NWA'(s1_prod) * NWA'(LOG2E_Q30) + NWA'(s1_den) * NWA'(819200);
    s2_dd   <= DWA'(s1_den) * DWA'(1638400);
    s2_side <= {s1_neg, s1_h};
  end

  // Exponent y = x*log2(e) in Q16, magnitude rounded half away from zero.
  logic           a_vld;
  logic [QA-1:0]  a_quo;
  logic [HUM_W:0] a_side;

  vpdds_div #(.NW(NWA), .DW(DWA), .QW(QA), .SW(HUM_W + 1)) u_div_exp (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s2_vld),
    .num      (s2_num),
    .den      (s2_dd),
    .side     (s2_side),
    .out_valid(a_vld),
    .quo      (a_quo),
    .ovf      (),
    .side_out (a_side)
  );

  // Stage 3: split y, read the mantissa table, form the humidity factor.
  logic signed [QA:0]  y_c;
  logic [15:0]         fr_c;
  logic [EXP_BITS:0]   idx_lo;
  logic [EXP_BITS:0]   idx_hi;
  logic                s3_vld;
  logic [31:0]         s3_t0;
  logic [31:0]         s3_t1;
  logic [15:0]         s3_frac;
  logic signed [QA-16:0] s3_ip;
  logic [29:0]         s3_p;

  assign y_c    = a_side[HUM_W] ? -signed'({1'b0, a_quo}) : signed'({1'b0, a_quo});
  assign fr_c   = y_c[15:0];
  assign idx_lo = {1'b0, fr_c[15 -: EXP_BITS]};
  assign idx_hi = idx_lo + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= a_vld;
    end
    s3_t0   <= POW2_TAB[idx_lo];
    s3_t1   <= POW2_TAB[idx_hi];
    s3_frac <= 16'(fr_c << EXP_BITS);
    s3_ip   <= y_c[QA:16];
    s3_p    <= 30'(14'd10000 - a_side[HUM_W-1:0]) * 30'd61100;
  end

  // Stage 4: linear interpolation of the mantissa.
  logic [31:0]           diff_c;
  logic [47:0]           interp_c;
  logic                  s4_vld;
  logic [31:0]           s4_m;
  logic signed [QA-16:0] s4_ip;
  logic [29:0]           s4_p;

  assign diff_c   = s3_t1 - s3_t0;
  assign interp_c = 48'(diff_c) * 48'(s3_frac);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
    s4_m  <= s3_t0 + 32'(interp_c >> 16);
    s4_ip <= s3_ip;
    s4_p  <= s3_p;
  end

  // Stage 5: product of mantissa, base pressure and humidity factor.
  logic                  s5_vld;
  logic [61:0]           s5_v;
  logic signed [QA-16:0] s5_ip;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else begin
      s5_vld <= s4_vld;
    end
    s5_v  <= 62'(s4_m) * 62'(s4_p);
    s5_ip <= s4_ip;
  end

  // Stage 6: scale by 2^(30-ip) with half up rounding of the final quotient.
  logic signed [7:0] sh_c;
  logic [63:0]       t_full;
  logic              s6_vld;
  logic [NWB-1:0]    s6_t;

  assign sh_c   = 8'sd30 - 8'(s5_ip);
  assign t_full = (64'(s5_v) + (64'd5000 << sh_c[5:0])) >> sh_c[5:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else begin
      s6_vld <= s5_vld;
    end
    s6_t <= (sh_c >= 8'sd50) ? '0 : NWB'(t_full);
  end

  // Deficit stage A: t/16, then partial products with the reciprocal of 625.
  logic [35:0] x_c;
  logic        sb_vld;
  logic        sb_sat;
  logic [35:0] sb_pp0;
  logic [35:0] sb_pp1;
  logic [35:0] sb_pp2;
  logic [35:0] sb_pp3;

  assign x_c = s6_t[39:4];

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_vld <= 1'b0;
    end else begin
      sb_vld <= s6_vld;
    end
    sb_sat <= s6_t >= T_SAT;
    sb_pp0 <= 36'(x_c[17:0])  * 36'(RECIP_625[17:0]);
    sb_pp1 <= 36'(x_c[17:0])  * 36'(RECIP_625[35:18]);
    sb_pp2 <= 36'(x_c[35:18]) * 36'(RECIP_625[17:0]);
    sb_pp3 <= 36'(x_c[35:18]) * 36'(RECIP_625[35:18]);
  end

  // Deficit stage B: sum the partial products and keep the quotient bits.
  logic [71:0]          prod_c;
  logic                 b_vld;
  logic [DEFICIT_W-1:0] b_quo;
  logic                 b_ovf;

  assign prod_c = 72'(sb_pp0) + (72'(sb_pp1) << 18) + (72'(sb_pp2) << 18)
                  + (72'(sb_pp3) << 36);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= sb_vld;
    end
    b_quo <= prod_c[70:45];
    b_ovf <= sb_sat;
  end

  // Stage 7: dose scale numerator and divisor from the reference deficit.
  logic [DEFICIT_W-1:0] d_c;
  logic [DWC-1:0]       div_c;
  logic                 s7_vld;
  logic [NWC-1:0]       s7_num;
  logic [DWC-1:0]       s7_div;
  logic [DEFICIT_W-1:0] s7_d;

  assign d_c   = b_ovf ? '1 : b_quo;
  assign div_c = ((reference_deficit_pa == '0) ? DWC'(1) : DWC'(reference_deficit_pa))
                 * DWC'(100);

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld <= 1'b0;
    end else begin
      s7_vld <= b_vld;
    end
    s7_num <= (NWC'(d_c) << SCALE_FRAC_BITS) + NWC'(div_c >> 1);
    s7_div <= div_c;
    s7_d   <= d_c;
  end

  // Dose scale quotient, saturating at the top of the field.
  logic                 c_vld;
  logic [QC-1:0]        c_quo;
  logic                 c_ovf;
  logic [DEFICIT_W-1:0] c_d;

  vpdds_div #(.NW(NWC), .DW(DWC), .QW(QC), .SW(DEFICIT_W)) u_div_scale (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s7_vld),
    .num      (s7_num),
    .den      (s7_div),
    .side     (s7_d),
    .out_valid(c_vld),
    .quo      (c_quo),
    .ovf      (c_ovf),
    .side_out (c_d)
  );

  // Stage 8: floor first, then ceiling, into the result register.
  logic [SCALE_W-1:0] sc_c;
  logic [SCALE_W-1:0] sc_fin;
  logic [1:0]         flag_c;

  assign sc_c = c_ovf ? '1 : c_quo;

  always_comb begin
    sc_fin = sc_c;
    flag_c = CLAMP_NONE;
    if (sc_c < scale_floor) begin
      sc_fin = scale_floor;
      flag_c = CLAMP_FLOOR;
    end
    if (sc_fin > scale_ceiling) begin
      sc_fin = scale_ceiling;
      flag_c = CLAMP_CEILING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c_vld;
    end
    result.deficit_centi_pa <= c_d;
    result.dose_scale       <= sc_fin;
    result.clamp_flag       <= flag_c;
  end

  // Every accepted transaction is followed by done high after the latency.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |-> ##LAT done)
    else $error("result missing after sample latency");

  // A floor clamp returns the floor itself.
  assert property (@(posedge clk) disable iff (rst)
      (done && result.clamp_flag == CLAMP_FLOOR) |-> result.dose_scale == scale_floor)
    else $error("floor clamp does not match floor register");

  // An unclamped scale lies within the configured limits.
  assert property (@(posedge clk) disable iff (rst)
      (done && result.clamp_flag == CLAMP_NONE)
      |-> (result.dose_scale >= scale_floor && result.dose_scale <= scale_ceiling))
    else $error("unclamped scale outside limits");

endmodule
